// ===== design/tohu_pkg.sv =====
// Shared types, constants and helper functions for the timeout header decoder.
package tohu_pkg;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       last_byte;
      logic       empty_header;
   } req_type;

   typedef struct packed {
      logic signed [63:0] timeout_us;
      logic               format_accepted;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      UNIT_HOUR,
      UNIT_MIN,
      UNIT_SEC,
      UNIT_MSEC,
      UNIT_USEC,
      UNIT_NSEC,
      UNIT_BAD
   } unit_type;

   typedef struct packed {
      unit_type    unit;
      logic        neg;
      logic [63:0] mag;
   } work_type;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_HOUR  = 8'd72;
   localparam logic [7:0] CH_MIN   = 8'd77;
   localparam logic [7:0] CH_SEC   = 8'd83;
   localparam logic [7:0] CH_MSEC  = 8'd109;
   localparam logic [7:0] CH_USEC  = 8'd117;
   localparam logic [7:0] CH_NSEC  = 8'd110;

   localparam logic [63:0] MAG_LIMIT      = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAG_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MAG_DIV10      = 64'd922337203685477580;
   localparam logic [3:0]  MAG_LAST_DIGIT = 4'd8;

   localparam logic [31:0] SCALE_HOUR = 32'd3600000000;
   localparam logic [31:0] SCALE_MIN  = 32'd60000000;
   localparam logic [31:0] SCALE_SEC  = 32'd1000000;
   localparam logic [31:0] SCALE_MSEC = 32'd1000;
   localparam logic [31:0] SCALE_USEC = 32'd1;

   localparam logic [63:0] NS_BIAS = 64'd500;

   // Divide by 1000 in 16-bit chunks; floor(x * DIV_MAGIC / 2^DIV_SHIFT) is exact for x < 2^26.
   localparam int          DIV_CHUNK_W = 16;
   localparam int          DIV_CHUNKS  = 64 / DIV_CHUNK_W;
   localparam int          DIV_REM_W   = 10;
   localparam int          DIV_X_W     = DIV_REM_W + DIV_CHUNK_W;
   localparam int          DIV_MAGIC_W = 27;
   localparam int          DIV_PROD_W  = DIV_X_W + DIV_MAGIC_W;
   localparam int          DIV_SHIFT   = 36;
   localparam logic [26:0] DIV_MAGIC   = 27'd68719477;

   function automatic unit_type unit_code(input logic [7:0] c);
      unit_type u;
      case (c)
         CH_HOUR: u = UNIT_HOUR;
         CH_MIN:  u = UNIT_MIN;
         CH_SEC:  u = UNIT_SEC;
         CH_MSEC: u = UNIT_MSEC;
         CH_USEC: u = UNIT_USEC;
         CH_NSEC: u = UNIT_NSEC;
         default: u = UNIT_BAD;
      endcase
      return u;
   endfunction

   function automatic logic [31:0] unit_scale(input unit_type u);
      logic [31:0] s;
      case (u)
         UNIT_HOUR: s = SCALE_HOUR;
         UNIT_MIN:  s = SCALE_MIN;
         UNIT_SEC:  s = SCALE_SEC;
         UNIT_MSEC: s = SCALE_MSEC;
         UNIT_USEC: s = SCALE_USEC;
         default:   s = 32'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== design/tohu_front.sv =====
// Front end: accepts header bytes, parses sign and digits, classifies the unit.
module tohu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tohu_pkg::req_type req_payload,
   input  logic              queue_full,
   output logic              push,
   output tohu_pkg::work_type push_rec
);

   tohu_pkg::phase_type phase_ff, phase_in, nx_phase;
   logic        neg_ff, neg_in, nx_neg;
   logic [63:0] mag_ff, mag_in, nx_mag;
   logic        sat_ff, sat_in, nx_sat;
   logic        seen_ff, seen_in, nx_seen;
   logic [1:0]  after_ff, after_in, nx_after;
   logic [1:0]  len_ff, len_in, nx_len;
   logic [7:0]  unit_ff, unit_in, nx_unit;

   logic        accept;
   logic        closing;
   logic [7:0]  c;
   logic        is_space;
   logic        is_digit;
   logic [3:0]  digit;
   logic        over;
   logic [63:0] mag_x10;
   logic        fmt_ok;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign closing   = req_payload.last_byte || req_payload.empty_header;
   assign c         = req_payload.header_byte;
   assign is_space  = (c == tohu_pkg::CH_SPACE) ||
                      (c >= tohu_pkg::CH_TAB && c <= tohu_pkg::CH_CR);
   assign is_digit  = (c >= tohu_pkg::CH_ZERO && c <= tohu_pkg::CH_NINE);
   assign digit     = c[3:0];
   assign over      = sat_ff || (mag_ff > tohu_pkg::MAG_DIV10) ||
                      (mag_ff == tohu_pkg::MAG_DIV10 && digit > tohu_pkg::MAG_LAST_DIGIT);
   assign mag_x10   = {mag_ff[60:0], 3'b000} + {mag_ff[62:0], 1'b0} + {60'd0, digit};

   // next state
   always_comb begin
      nx_phase = phase_ff;
      nx_neg   = neg_ff;
      nx_mag   = mag_ff;
      nx_sat   = sat_ff;
      nx_seen  = seen_ff;
      nx_after = after_ff;
      nx_len   = (len_ff < 2'd2) ? len_ff + 2'd1 : len_ff;
      nx_unit  = (len_ff == 2'd0) ? c : unit_ff;
      case (phase_ff)
         tohu_pkg::PH_SPACE: begin
            if (is_space) begin
               nx_phase = tohu_pkg::PH_SPACE;
            end else if (c == tohu_pkg::CH_PLUS || c == tohu_pkg::CH_MINUS) begin
               nx_neg   = (c == tohu_pkg::CH_MINUS);
               nx_phase = tohu_pkg::PH_SIGN;
            end else if (is_digit) begin
               nx_seen  = 1'b1;
               nx_mag   = over ? tohu_pkg::MAG_LIMIT : mag_x10;
               nx_sat   = over;
               nx_phase = tohu_pkg::PH_DIGITS;
            end else begin
               nx_phase = tohu_pkg::PH_DONE;
            end
         end
         tohu_pkg::PH_SIGN: begin
            if (is_digit) begin
               nx_seen  = 1'b1;
               nx_mag   = over ? tohu_pkg::MAG_LIMIT : mag_x10;
               nx_sat   = over;
               nx_phase = tohu_pkg::PH_DIGITS;
            end else begin
               nx_phase = tohu_pkg::PH_DONE;
            end
         end
         tohu_pkg::PH_DIGITS: begin
            if (is_digit) begin
               nx_mag = over ? tohu_pkg::MAG_LIMIT : mag_x10;
               nx_sat = over;
            end else begin
               nx_unit  = c;
               nx_after = 2'd1;
               nx_phase = tohu_pkg::PH_DONE;
            end
         end
         default: begin
            if (seen_ff && after_ff < 2'd2) begin
               nx_after = after_ff + 2'd1;
            end
         end
      endcase

      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      sat_in   = sat_ff;
      seen_in  = seen_ff;
      after_in = after_ff;
      len_in   = len_ff;
      unit_in  = unit_ff;
      if (accept) begin
         if (closing) begin
            phase_in = tohu_pkg::PH_SPACE;
            neg_in   = 1'b0;
            mag_in   = '0;
            sat_in   = 1'b0;
            seen_in  = 1'b0;
            after_in = '0;
            len_in   = '0;
            unit_in  = '0;
         end else begin
            phase_in = nx_phase;
            neg_in   = nx_neg;
            mag_in   = nx_mag;
            sat_in   = nx_sat;
            seen_in  = nx_seen;
            after_in = nx_after;
            len_in   = nx_len;
            unit_in  = nx_unit;
         end
      end
   end

   // outputs
   always_comb begin
      fmt_ok        = nx_seen ? (nx_after == 2'd1) : (nx_len == 2'd1);
      push          = accept && closing;
      push_rec.neg  = nx_neg && nx_seen;
      push_rec.mag  = nx_mag;
      push_rec.unit = (req_payload.empty_header || !fmt_ok) ? tohu_pkg::UNIT_BAD
                                                            : tohu_pkg::unit_code(nx_unit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tohu_pkg::PH_SPACE;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         sat_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         after_ff <= '0;
         len_ff   <= '0;
         unit_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
         sat_ff   <= sat_in;
         seen_ff  <= seen_in;
         after_ff <= after_in;
         len_ff   <= len_in;
         unit_ff  <= unit_in;
      end
   end

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      accept && closing |=> phase_ff == tohu_pkg::PH_SPACE && !seen_ff && len_ff == 2'd0)
      else $error("parse state not cleared after header close");

endmodule

// ===== design/tohu_queue.sv =====
// Short queue of parsed headers between the front end and the arithmetic pipeline.
module tohu_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tohu_pkg::work_type push_rec,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output tohu_pkg::work_type pop_rec
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tohu_pkg::work_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_rec   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

// ===== design/tohu_back.sv =====
// Back end: sign and clamp, unit multiply, nanosecond divide, result register.
module tohu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  tohu_pkg::work_type pop_rec,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tohu_pkg::rsp_type  rsp_payload
);

   localparam int NSTG = 3 + 2 * tohu_pkg::DIV_CHUNKS;

   typedef struct packed {
      tohu_pkg::unit_type              unit;
      logic                            t_neg;
      logic [63:0]                     val;
      logic [63:0]                     t;
      logic [63:0]                     a;
      logic [63:0]                     p_lo;
      logic [31:0]                     p_hi;
      logic [63:0]                     prod;
      logic [tohu_pkg::DIV_X_W-1:0]     x;
      logic [tohu_pkg::DIV_CHUNK_W-1:0] q;
      logic [tohu_pkg::DIV_REM_W-1:0]   rem;
      logic [63:0]                     quo;
   } stage_type;

   stage_type stg_ff [NSTG];
   stage_type stg_in [NSTG];
   logic [NSTG-1:0] vld_ff, vld_in;

   logic [tohu_pkg::DIV_PROD_W-1:0] mprod    [tohu_pkg::DIV_CHUNKS];
   logic [tohu_pkg::DIV_X_W-1:0]    rem_full [tohu_pkg::DIV_CHUNKS];
   logic [tohu_pkg::DIV_X_W-1:0]    x_cur    [tohu_pkg::DIV_CHUNKS];

   logic              rsp_valid_ff, rsp_valid_in;
   tohu_pkg::rsp_type rsp_ff, rsp_in;
   logic              advance;
   logic [63:0]       ns_q;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign pop         = advance && pop_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      stg_in[0]      = stg_ff[0];
      stg_in[0].unit = pop_rec.unit;
      stg_in[0].val  = pop_rec.neg ? 64'd0 - pop_rec.mag
                     : (pop_rec.mag[63] ? tohu_pkg::MAG_MAX : pop_rec.mag);
      for (int i = 1; i < NSTG; i++) begin
         stg_in[i] = stg_ff[i-1];
      end

      stg_in[1].t    = stg_ff[0].val + tohu_pkg::NS_BIAS;
      stg_in[1].p_lo = {32'd0, stg_ff[0].val[31:0]} *
                       {32'd0, tohu_pkg::unit_scale(stg_ff[0].unit)};

      stg_in[2].t_neg = stg_ff[1].t[63];
      stg_in[2].a     = stg_ff[1].t[63] ? 64'd0 - stg_ff[1].t : stg_ff[1].t;
      stg_in[2].p_hi  = stg_ff[1].val[63:32] * tohu_pkg::unit_scale(stg_ff[1].unit);
      stg_in[2].rem   = '0;
      stg_in[2].quo   = '0;

      for (int k = 0; k < tohu_pkg::DIV_CHUNKS; k++) begin
         x_cur[k] = {stg_ff[2+2*k].rem,
                     stg_ff[2+2*k].a[64-tohu_pkg::DIV_CHUNK_W*(k+1) +: tohu_pkg::DIV_CHUNK_W]};
         mprod[k] = {{tohu_pkg::DIV_MAGIC_W{1'b0}}, x_cur[k]} *
                    {{tohu_pkg::DIV_X_W{1'b0}}, tohu_pkg::DIV_MAGIC};
         stg_in[3+2*k].x = x_cur[k];
         stg_in[3+2*k].q = mprod[k][tohu_pkg::DIV_SHIFT +: tohu_pkg::DIV_CHUNK_W];

         rem_full[k] = stg_ff[3+2*k].x -
                       ({stg_ff[3+2*k].q, 10'd0} -
                        {6'd0, stg_ff[3+2*k].q, 4'd0} -
                        {7'd0, stg_ff[3+2*k].q, 3'd0});
         stg_in[4+2*k].rem = rem_full[k][tohu_pkg::DIV_REM_W-1:0];
         stg_in[4+2*k].quo = {stg_ff[3+2*k].quo[63-tohu_pkg::DIV_CHUNK_W:0],
                              stg_ff[3+2*k].q};
      end

      stg_in[3].prod = stg_ff[2].p_lo + {stg_ff[2].p_hi, 32'd0};
   end

   always_comb begin
      vld_in = {vld_ff[NSTG-2:0], pop_valid};
   end

   always_comb begin
      ns_q         = stg_ff[NSTG-1].t_neg ? 64'd0 - stg_ff[NSTG-1].quo : stg_ff[NSTG-1].quo;
      rsp_valid_in = vld_ff[NSTG-1];
      case (stg_ff[NSTG-1].unit)
         tohu_pkg::UNIT_BAD: begin
            rsp_in.timeout_us      = -64'sd1;
            rsp_in.format_accepted = 1'b0;
         end
         tohu_pkg::UNIT_NSEC: begin
            rsp_in.timeout_us      = (stg_ff[NSTG-1].quo == '0) ? 64'sd1 : ns_q;
            rsp_in.format_accepted = 1'b1;
         end
         default: begin
            rsp_in.timeout_us      = stg_ff[NSTG-1].prod;
            rsp_in.format_accepted = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NSTG; i++) begin
            stg_ff[i] <= stg_in[i];
         end
         rsp_ff <= rsp_in;
      end
   end

   a_reject_is_minus_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.format_accepted |-> rsp_ff.timeout_us == -64'sd1)
      else $error("rejected header without -1 result");

   a_frozen_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff) && $stable(rsp_valid_ff))
      else $error("pipeline moved while output stalled");

endmodule

// ===== design/timeout_header_to_microseconds_unit.sv =====
// Top level of the timeout header decoder: front parser, queue, arithmetic back end.
//
//   port group    dir   carries
//   req_*         in    one header byte per request, with last and empty marks
//   rsp_*         out   timeout in microseconds and format flag, one per header
//
// One request per cycle while the queue has room; each accepted byte updates the registered parse state.
// A closing request's result passes through the queue and the back pipeline (unit multiply
// alongside the four-chunk divide-by-1000) into the result register.
// Reset clears the parse state, the queue and all pipeline valids.
// A stalled result freezes the back pipeline; requests keep flowing until the
// queue fills, then req_stall rises.
module timeout_header_to_microseconds_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tohu_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tohu_pkg::rsp_type rsp_payload
);

   logic               push;
   tohu_pkg::work_type push_rec;
   logic               queue_full;
   logic               pop;
   logic               pop_valid;
   tohu_pkg::work_type pop_rec;

   tohu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_rec    (push_rec)
   );

   tohu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_rec   (pop_rec)
   );

   tohu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_rec     (pop_rec),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== bench/timeout_header_to_microseconds_unit_tb.sv =====
// Self-checking testbench for the timeout header decoder: directed and random headers.
class timeout_scoreboard;
   tohu_pkg::rsp_type   expected_q[$];
   int unsigned         mismatches;
   tohu_pkg::phase_type phase;
   bit                  neg;
   logic [63:0]         mag;
   bit                  sat;
   bit                  seen;
   int                  after_cnt;
   int                  total_len;
   logic [7:0]          unit_ch;

   function new();
      mismatches = 0;
      clear_header();
   endfunction

   function void clear_header();
      phase     = tohu_pkg::PH_SPACE;
      neg       = 1'b0;
      mag       = '0;
      sat       = 1'b0;
      seen      = 1'b0;
      after_cnt = 0;
      total_len = 0;
      unit_ch   = '0;
   endfunction

   function void take_digit(logic [7:0] c);
      logic [3:0] d;
      d = 4'(c - tohu_pkg::CH_ZERO);
      seen = 1'b1;
      phase = tohu_pkg::PH_DIGITS;
      if (sat || mag > tohu_pkg::MAG_DIV10 ||
          (mag == tohu_pkg::MAG_DIV10 && d > tohu_pkg::MAG_LAST_DIGIT)) begin
         mag = tohu_pkg::MAG_LIMIT;
         sat = 1'b1;
      end else begin
         mag = mag * 64'd10 + 64'(d);
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void note_request(tohu_pkg::req_type r);
      logic [7:0]        c;
      logic [63:0]       val;
      logic [63:0]       res;
      longint            q;
      bit                ok;
      bit                is_digit;
      tohu_pkg::rsp_type e;
      c = r.header_byte;
      is_digit = (c >= tohu_pkg::CH_ZERO && c <= tohu_pkg::CH_NINE);
      if (r.empty_header) begin
         clear_header();
         e.timeout_us = '1;
         e.format_accepted = 1'b0;
         expected_q.push_back(e);
         return;
      end
      if (total_len == 0) unit_ch = c;
      if (total_len < 2) total_len++;
      case (phase)
         tohu_pkg::PH_SPACE: begin
            if (!(c == tohu_pkg::CH_SPACE ||
                  (c >= tohu_pkg::CH_TAB && c <= tohu_pkg::CH_CR))) begin
               if (c == tohu_pkg::CH_PLUS || c == tohu_pkg::CH_MINUS) begin
                  neg = (c == tohu_pkg::CH_MINUS);
                  phase = tohu_pkg::PH_SIGN;
               end else if (is_digit) begin
                  take_digit(c);
               end else begin
                  phase = tohu_pkg::PH_DONE;
               end
            end
         end
         tohu_pkg::PH_SIGN: begin
            if (is_digit) take_digit(c);
            else phase = tohu_pkg::PH_DONE;
         end
         tohu_pkg::PH_DIGITS: begin
            if (is_digit) begin
               take_digit(c);
            end else begin
               unit_ch = c;
               after_cnt = 1;
               phase = tohu_pkg::PH_DONE;
            end
         end
         default: begin
            if (seen && after_cnt < 2) after_cnt++;
         end
      endcase
      if (!r.last_byte) return;
      if (seen) begin
         ok = (after_cnt == 1);
         if (neg) val = -mag;
         else val = (mag >= tohu_pkg::MAG_LIMIT) ? tohu_pkg::MAG_MAX : mag;
      end else begin
         ok = (total_len == 1);
         val = '0;
      end
      res = '1;
      if (ok) begin
         case (unit_ch)
            tohu_pkg::CH_HOUR: res = val * tohu_pkg::SCALE_HOUR;
            tohu_pkg::CH_MIN:  res = val * tohu_pkg::SCALE_MIN;
            tohu_pkg::CH_SEC:  res = val * tohu_pkg::SCALE_SEC;
            tohu_pkg::CH_MSEC: res = val * tohu_pkg::SCALE_MSEC;
            tohu_pkg::CH_USEC: res = val;
            tohu_pkg::CH_NSEC: begin
               q = longint'(val + tohu_pkg::NS_BIAS) / 1000;
               if (q == 0) q = 1;
               res = q;
            end
            default: ok = 1'b0;
         endcase
      end
      clear_header();
      e.timeout_us = ok ? res : '1;
      e.format_accepted = ok;
      expected_q.push_back(e);
   endfunction

   function void check_response(tohu_pkg::rsp_type r, realtime stamp);
      tohu_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         $display("%0.1f ns: unexpected result, expected none, got %0d / %0b",
                  stamp, r.timeout_us, r.format_accepted);
         mismatches++;
         return;
      end
      e = expected_q.pop_front();
      if (r.timeout_us !== e.timeout_us) begin
         $display("%0.1f ns: timeout_us expected %0d got %0d",
                  stamp, e.timeout_us, r.timeout_us);
         mismatches++;
      end
      if (r.format_accepted !== e.format_accepted) begin
         $display("%0.1f ns: format_accepted expected %0b got %0b",
                  stamp, e.format_accepted, r.format_accepted);
         mismatches++;
      end
   endfunction
endclass

module timeout_header_to_microseconds_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 1000000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   tohu_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   tohu_pkg::rsp_type rsp_payload;

   timeout_scoreboard board = new();
   logic [7:0]        hdr_q[$];
   int                sent_items;
   int                cycle_count = 0;
   bit                quiet;

   timeout_header_to_microseconds_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_payload);
         if (rsp_valid && !rsp_stall) board.check_response(rsp_payload, $realtime);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [7:0] rand_unit();
      case ($urandom_range(0, 5))
         0: return tohu_pkg::CH_HOUR;
         1: return tohu_pkg::CH_MIN;
         2: return tohu_pkg::CH_SEC;
         3: return tohu_pkg::CH_MSEC;
         4: return tohu_pkg::CH_USEC;
         default: return tohu_pkg::CH_NSEC;
      endcase
   endfunction

   function automatic logic [7:0] rand_digit();
      return tohu_pkg::CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_space();
      if ($urandom_range(0, 1)) return tohu_pkg::CH_SPACE;
      return tohu_pkg::CH_TAB + 8'($urandom_range(0, 4));
   endfunction

   function automatic logic [7:0] rand_any();
      case ($urandom_range(0, 5))
         0: return rand_digit();
         1: return rand_space();
         2: return $urandom_range(0, 1) ? tohu_pkg::CH_PLUS : tohu_pkg::CH_MINUS;
         3: return rand_unit();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
   endfunction

   function automatic void push_number();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 75) n = $urandom_range(1, 4);
      else if (r < 85) n = $urandom_range(5, 12);
      else if (r < 93) n = 0;
      else n = $urandom_range(20, 25);
      if (n == 0) begin
         if ($urandom_range(0, 1)) begin
            push_text("922337203685477580");
            hdr_q.push_back(rand_digit());
         end else begin
            push_text("922337203685477");
            repeat (4) hdr_q.push_back(rand_digit());
         end
      end else begin
         repeat (n) hdr_q.push_back(rand_digit());
      end
   endfunction

   function automatic void push_prefix();
      repeat ($urandom_range(0, 3) == 3 ? $urandom_range(1, 2) : 0)
         hdr_q.push_back(rand_space());
      case ($urandom_range(0, 3))
         0: hdr_q.push_back(tohu_pkg::CH_PLUS);
         1: hdr_q.push_back(tohu_pkg::CH_MINUS);
         default: ;
      endcase
   endfunction

   task automatic send_request(tohu_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic send_header(bit close);
      tohu_pkg::req_type r;
      foreach (hdr_q[i]) begin
         r.header_byte  = hdr_q[i];
         r.last_byte    = close && (i == hdr_q.size() - 1);
         r.empty_header = 1'b0;
         send_request(r);
      end
      hdr_q.delete();
   endtask

   task automatic send_empty(logic [7:0] b, logic l);
      tohu_pkg::req_type r;
      r.header_byte  = b;
      r.last_byte    = l;
      r.empty_header = 1'b1;
      send_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random_header();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         push_prefix();
         push_number();
         hdr_q.push_back($urandom_range(0, 9) == 0 ? rand_any() : rand_unit());
         send_header(1'b1);
      end else if (r < 68) begin
         hdr_q.push_back($urandom_range(0, 1) ? rand_unit() : 8'($urandom_range(0, 255)));
         send_header(1'b1);
      end else if (r < 78) begin
         push_prefix();
         push_number();
         if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(2, 3)) hdr_q.push_back(rand_any());
         end
         send_header(1'b1);
      end else if (r < 88) begin
         repeat ($urandom_range(1, 6)) hdr_q.push_back(rand_any());
         send_header(1'b1);
      end else if (r < 94) begin
         push_prefix();
         repeat ($urandom_range(1, 4)) hdr_q.push_back(rand_any());
         send_header(1'b0);
         send_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
         send_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!quiet) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
               @(posedge clock);
         end
      end
   end

   initial begin
      bit paused;
      req_valid   <= 1'b0;
      req_payload <= '0;
      reset       <= 1'b1;
      sent_items  = 0;
      quiet       = 1'b0;
      paused      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_empty(8'hFF, 1'b1);
      push_text("n");    send_header(1'b1);
      push_text("5u");   send_header(1'b1);
      push_text(" -7m"); send_header(1'b1);
      push_text("\t+3H"); send_header(1'b1);
      push_text("12M");  send_header(1'b1);
      push_text("4x");   send_header(1'b1);
      push_text("9SS");  send_header(1'b1);
      push_text("ab");   send_header(1'b1);
      push_text("99n");  send_header(1'b1);
      hdr_q.push_back(8'hFF); send_header(1'b1);
      push_text("3");    send_header(1'b0);
      send_empty(8'h00, 1'b0);

      sent_items = 0;
      while (sent_items < RANDOM_ITEMS) begin
         quiet = (sent_items >= 400 && sent_items < 700);
         if (!paused && sent_items >= 900) begin
            drain();
            paused = 1'b1;
         end
         send_random_header();
      end

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
